[hw/rtl/tasr_pkg.sv]
// Package for the tensor axis sum reduction block.
// Holds register codes, field widths and shape limits shared by the RTL and its checker.
// No dependencies.
`timescale 1ns / 1ps

package tasr_pkg;

   localparam int unsigned NUM_SHAPES = 4;
   localparam int unsigned MAX_DIMS   = 4;
   localparam int unsigned SHAPE_W    = 13;
   localparam int unsigned SHAPE_MAX  = 4096;
   localparam int unsigned AXIS_W     = 2;
   localparam int unsigned NDIMS_W    = 3;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned INDEX_W    = 24;
   localparam int unsigned COUNT_W    = INDEX_W + 1;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = SHAPE_W;

   typedef logic [SHAPE_W-1:0] shape_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHAPE_0     = 3'd0,
      CSR_SHAPE_1     = 3'd1,
      CSR_SHAPE_2     = 3'd2,
      CSR_SHAPE_3     = 3'd3,
      CSR_REDUCE_AXIS = 3'd4,
      CSR_NUM_DIMS    = 3'd5
   } csr_index_type;

   // any count above the index span saturates to this
   localparam logic [COUNT_W-1:0] COUNT_CAP  = COUNT_W'((1 << INDEX_W) + 1);
   localparam logic [COUNT_W-1:0] INDEX_SPAN = COUNT_W'(1 << INDEX_W);

endpackage

[hw/rtl/tensor_axis_sum_reduce.sv]
// Tensor sum reduction along one configured axis, one element per item.
// Partial sums live in a one-port-read, one-port-write synchronous memory.
// Depends on tasr_pkg.
//
// Usage:
//   Elements of a tensor of up to four dimensions arrive on the req_ channel in
//   row-major order, one signed Q16.16 value per item. The csr_ port sets the
//   four shapes, the reduced axis and the dimension count; each such write
//   restarts the tensor and runs a derivation of the outer, axis and inner
//   counts, during which req_stall is high.
//   Every element whose axis step is the last gives one rsp_ item with the
//   saturated Q32.16 sum, its flat row-major output index and a last-of-tensor
//   flag. With an invalid configuration every element gives one item with
//   rsp_config_error set and all other fields zero.
//   Throughput is one item per cycle unless a derivation runs or rsp_stall
//   holds a result, set by the single read-modify-write of the partial-sum
//   memory per element; a result goes from the compute stage to the rsp_ output
//   register. A read during a write to the same entry uses a bypass register.
//   Reset clears all positions and loads shapes of one, axis zero and one
//   dimension; the memory needs no clearing since each entry is written at the
//   first axis step. While rsp_stall holds a result, elements keep entering
//   until one that completes a sum reaches the compute stage; then req_stall
//   rises.
`timescale 1ns / 1ps

module tensor_axis_sum_reduce
   import tasr_pkg::*;
#(
   parameter int unsigned INNER_DEPTH = 1024,
   parameter int unsigned ACC_WIDTH   = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [VALUE_W-1:0]   req_in_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [ACC_WIDTH-1:0] rsp_sum_value,
   output logic [INDEX_W-1:0]          rsp_out_index,
   output logic                        rsp_last_result,
   output logic                        rsp_config_error,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data
);

   localparam int unsigned AW = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;
   localparam int unsigned CW = $clog2(INNER_DEPTH + 1);

   typedef struct packed {
      logic                 err;
      logic                 emit;
      logic                 first;
      logic                 last;
      logic                 fwd;
      logic [AW-1:0]        addr;
      logic [INDEX_W-1:0]   index;
      logic [VALUE_W-1:0]   value;
   } stage_type;

   typedef enum logic [1:0] {
      D_IDLE,
      D_SCAN,
      D_DONE
   } derive_state_type;

   // configuration registers
   shape_type                shape_ff [NUM_SHAPES];
   logic [AXIS_W-1:0]        axis_sel_ff;
   logic [NDIMS_W-1:0]       num_dims_ff;

   // derivation
   derive_state_type         dstate_ff;
   logic [AXIS_W-1:0]        dim_ff;
   logic [COUNT_W-1:0]       d_outer_ff;
   logic [COUNT_W-1:0]       d_inner_ff;
   shape_type                d_axis_ff;
   logic                     d_bad_ff;

   // derived counts
   logic [COUNT_W-1:0]       outer_count_ff;
   logic [CW-1:0]            inner_count_ff;
   shape_type                axis_count_ff;
   logic                     cfg_bad_ff;

   // positions
   logic [AW-1:0]            inner_pos_ff;
   logic [SHAPE_W-2:0]       axis_pos_ff;
   logic [INDEX_W-1:0]       outer_pos_ff;
   logic [COUNT_W-1:0]       base_ff;

   // compute stage and memory
   logic                     s1_valid_ff;
   stage_type                s1_ff;
   stage_type                s1_in;
   logic [ACC_WIDTH-1:0]     mem [INNER_DEPTH];
   logic [ACC_WIDTH-1:0]     rd_data_ff;
   logic [ACC_WIDTH-1:0]     bypass_ff;

   logic                     cfg_write;
   logic                     commit;
   logic                     req_accept;
   logic                     s1_advance;
   logic                     s1_write;
   logic                     inner_wrap;
   logic                     axis_wrap;
   logic                     outer_wrap;
   shape_type                cur_shape;
   logic                     dim_used;
   logic [COUNT_W-1:0]       mul_oper;
   logic [COUNT_W+SHAPE_W-1:0] mul_prod;
   logic [COUNT_W-1:0]       mul_capped;
   logic [2*COUNT_W-1:0]     span_prod;
   logic                     final_bad;
   logic [ACC_WIDTH-1:0]     old_sum;
   logic signed [ACC_WIDTH:0] wide_sum;
   logic [ACC_WIDTH-1:0]     new_sum;

   // configuration write port
   assign cfg_write = csr_write_enable && (csr_index <= CSR_IDX_W'(CSR_NUM_DIMS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SHAPES; i++) begin
            shape_ff[i] <= SHAPE_W'(1);
         end
         axis_sel_ff <= '0;
         num_dims_ff <= NDIMS_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SHAPE_0:     shape_ff[0] <= csr_write_data;
            CSR_SHAPE_1:     shape_ff[1] <= csr_write_data;
            CSR_SHAPE_2:     shape_ff[2] <= csr_write_data;
            CSR_SHAPE_3:     shape_ff[3] <= csr_write_data;
            CSR_REDUCE_AXIS: axis_sel_ff <= csr_write_data[AXIS_W-1:0];
            CSR_NUM_DIMS:    num_dims_ff <= csr_write_data[NDIMS_W-1:0];
            default: ;
         endcase
      end
   end

   // derivation: one dimension a cycle through a shared multiplier
   assign cur_shape  = shape_ff[dim_ff];
   assign dim_used   = NDIMS_W'(dim_ff) < num_dims_ff;
   assign mul_oper   = (dim_ff < axis_sel_ff) ? d_outer_ff : d_inner_ff;
   assign mul_prod   = (COUNT_W+SHAPE_W)'(mul_oper) * (COUNT_W+SHAPE_W)'(cur_shape);
   assign mul_capped = (mul_prod > (COUNT_W+SHAPE_W)'(INDEX_SPAN)) ? COUNT_CAP
                                                                  : mul_prod[COUNT_W-1:0];
   assign span_prod  = (2*COUNT_W)'(d_outer_ff) * (2*COUNT_W)'(d_inner_ff);
   assign final_bad  = d_bad_ff
                    || (num_dims_ff == '0)
                    || (num_dims_ff > NDIMS_W'(MAX_DIMS))
                    || (NDIMS_W'(axis_sel_ff) >= num_dims_ff)
                    || (d_inner_ff > COUNT_W'(INNER_DEPTH))
                    || (span_prod > (2*COUNT_W)'(INDEX_SPAN));
   assign commit     = (dstate_ff == D_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff      <= D_IDLE;
         dim_ff         <= '0;
         d_outer_ff     <= COUNT_W'(1);
         d_inner_ff     <= COUNT_W'(1);
         d_axis_ff      <= SHAPE_W'(1);
         d_bad_ff       <= 1'b0;
         outer_count_ff <= COUNT_W'(1);
         inner_count_ff <= CW'(1);
         axis_count_ff  <= SHAPE_W'(1);
         cfg_bad_ff     <= 1'b0;
      end else if (cfg_write) begin
         dstate_ff  <= D_SCAN;
         dim_ff     <= '0;
         d_outer_ff <= COUNT_W'(1);
         d_inner_ff <= COUNT_W'(1);
         d_axis_ff  <= SHAPE_W'(1);
         d_bad_ff   <= 1'b0;
      end else begin
         unique case (dstate_ff)
            D_IDLE: ;
            D_SCAN: begin
               if (dim_used) begin
                  if ((cur_shape == '0) || (cur_shape > SHAPE_W'(SHAPE_MAX))) begin
                     d_bad_ff <= 1'b1;
                  end else if (dim_ff < axis_sel_ff) begin
                     d_outer_ff <= mul_capped;
                  end else if (dim_ff == axis_sel_ff) begin
                     d_axis_ff <= cur_shape;
                  end else begin
                     d_inner_ff <= mul_capped;
                  end
               end
               dim_ff <= dim_ff + AXIS_W'(1);
               if (dim_ff == AXIS_W'(NUM_SHAPES - 1)) begin
                  dstate_ff <= D_DONE;
               end
            end
            D_DONE: begin
               cfg_bad_ff <= final_bad;
               if (final_bad) begin
                  outer_count_ff <= COUNT_W'(1);
                  inner_count_ff <= CW'(1);
                  axis_count_ff  <= SHAPE_W'(1);
               end else begin
                  outer_count_ff <= d_outer_ff;
                  inner_count_ff <= d_inner_ff[CW-1:0];
                  axis_count_ff  <= d_axis_ff;
               end
               dstate_ff <= D_IDLE;
            end
            default: dstate_ff <= D_IDLE;
         endcase
      end
   end

   // input acceptance and position tracking
   assign s1_advance = !s1_valid_ff || !s1_ff.emit || !rsp_valid || !rsp_stall;
   assign req_stall  = (dstate_ff != D_IDLE) || (s1_valid_ff && !s1_advance);
   assign req_accept = req_valid && !req_stall;
   assign s1_write   = s1_valid_ff && s1_advance && !s1_ff.err;

   assign inner_wrap = ((CW+1)'(inner_pos_ff) + (CW+1)'(1)) >= (CW+1)'(inner_count_ff);
   assign axis_wrap  = (SHAPE_W'(axis_pos_ff) + SHAPE_W'(1)) >= axis_count_ff;
   assign outer_wrap = (COUNT_W'(outer_pos_ff) + COUNT_W'(1)) >= outer_count_ff;

   always_comb begin
      s1_in       = '0;
      s1_in.value = req_in_value;
      if (cfg_bad_ff) begin
         s1_in.err  = 1'b1;
         s1_in.emit = 1'b1;
      end else begin
         s1_in.emit  = axis_wrap;
         s1_in.first = (axis_pos_ff == '0);
         s1_in.last  = outer_wrap && inner_wrap;
         s1_in.addr  = inner_pos_ff;
         s1_in.index = INDEX_W'(base_ff + COUNT_W'(inner_pos_ff));
         s1_in.fwd   = s1_write && (s1_ff.addr == inner_pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || commit) begin
         inner_pos_ff <= '0;
         axis_pos_ff  <= '0;
         outer_pos_ff <= '0;
         base_ff      <= '0;
      end else if (req_accept && !cfg_bad_ff) begin
         if (inner_wrap) begin
            inner_pos_ff <= '0;
            if (axis_wrap) begin
               axis_pos_ff <= '0;
               if (outer_wrap) begin
                  outer_pos_ff <= '0;
                  base_ff      <= '0;
               end else begin
                  outer_pos_ff <= outer_pos_ff + INDEX_W'(1);
                  base_ff      <= base_ff + COUNT_W'(inner_count_ff);
               end
            end else begin
               axis_pos_ff <= axis_pos_ff + (SHAPE_W-1)'(1);
            end
         end else begin
            inner_pos_ff <= inner_pos_ff + AW'(1);
         end
      end
   end

   // compute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept || (s1_valid_ff && !s1_advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   assign old_sum  = s1_ff.first ? '0 : (s1_ff.fwd ? bypass_ff : rd_data_ff);
   assign wide_sum = $signed({old_sum[ACC_WIDTH-1], old_sum})
                   + $signed({{(ACC_WIDTH+1-VALUE_W){s1_ff.value[VALUE_W-1]}}, s1_ff.value});

   always_comb begin
      if (wide_sum[ACC_WIDTH] != wide_sum[ACC_WIDTH-1]) begin
         new_sum = wide_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                       : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         new_sum = wide_sum[ACC_WIDTH-1:0];
      end
   end

   // partial-sum memory
   always_ff @(posedge clock) begin
      if (s1_write) begin
         mem[s1_ff.addr] <= new_sum;
         bypass_ff       <= new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= mem[inner_pos_ff];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (s1_valid_ff && s1_advance && s1_ff.emit) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance && s1_ff.emit) begin
         rsp_sum_value    <= s1_ff.err ? '0 : new_sum;
         rsp_out_index    <= s1_ff.index;
         rsp_last_result  <= s1_ff.last;
         rsp_config_error <= s1_ff.err;
      end
   end

endmodule

[hw/rtl/tasr_checker.sv]
// Port-level checker for the tensor axis sum reduction block, with its bind.
// Depends on tasr_pkg and the tensor_axis_sum_reduce top level.
`timescale 1ns / 1ps

module tasr_checker
   import tasr_pkg::*;
#(
   parameter int unsigned ACC_WIDTH = 48
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [ACC_WIDTH-1:0] rsp_sum_value,
   input logic [INDEX_W-1:0]          rsp_out_index,
   input logic                        rsp_last_result,
   input logic                        rsp_config_error,
   input logic                        csr_write_enable,
   input logic [CSR_IDX_W-1:0]        csr_index
);

   a_reset_drops_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stalled_item_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_value)
                                 && $stable(rsp_out_index))
      else $error("stalled result item changed");

   a_error_item_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |-> (rsp_sum_value == '0)
                                        && (rsp_out_index == '0) && !rsp_last_result)
      else $error("error item carries data");

   a_last_not_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !rsp_config_error)
      else $error("last flag on an error item");

   a_csr_write_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && (csr_index <= CSR_IDX_W'(CSR_NUM_DIMS)) |=> req_stall)
      else $error("input not stalled during count derivation");

endmodule

bind tensor_axis_sum_reduce tasr_checker #(
   .ACC_WIDTH (ACC_WIDTH)
) u_tasr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sum_value    (rsp_sum_value),
   .rsp_out_index    (rsp_out_index),
   .rsp_last_result  (rsp_last_result),
   .rsp_config_error (rsp_config_error),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index)
);

[sim/tasr_sum_checker.sv]
// Scoreboard for tensor_axis_sum_reduce: follows csr_ writes and accepted req_ items,
// predicts each sum result and compares it field by field with the rsp_ channel.
// Depends on tasr_pkg.
`timescale 1ns / 1ps

module tasr_sum_checker
   import tasr_pkg::*;
#(
   parameter int unsigned INNER_DEPTH = 1024,
   parameter int unsigned ACC_WIDTH   = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [VALUE_W-1:0]   req_in_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [ACC_WIDTH-1:0] rsp_sum_value,
   input  logic [INDEX_W-1:0]          rsp_out_index,
   input  logic                        rsp_last_result,
   input  logic                        rsp_config_error,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data,
   output int                          fail_count,
   output int                          pending_results
);

   typedef logic signed [ACC_WIDTH-1:0] sum_type;

   typedef struct packed {
      sum_type            sum_value;
      logic [INDEX_W-1:0] out_index;
      logic               last_result;
      logic               config_error;
   } axis_sum_type;

   shape_type          shape_size [NUM_SHAPES];
   logic [AXIS_W-1:0]  axis_sel;
   logic [NDIMS_W-1:0] dims_used;
   bit                 config_bad;
   longint unsigned    outer_count, axis_count, inner_count;
   longint unsigned    outer_pos, axis_pos, inner_pos;
   sum_type            partial_sum [INNER_DEPTH];
   axis_sum_type       expected_sums [$];

   function automatic sum_type clamp_add(input sum_type acc,
                                         input logic signed [VALUE_W-1:0] v);
      logic signed [ACC_WIDTH:0] wide;
      wide = $signed({acc[ACC_WIDTH-1], acc})
           + $signed({{(ACC_WIDTH+1-VALUE_W){v[VALUE_W-1]}}, v});
      if (wide[ACC_WIDTH] == wide[ACC_WIDTH-1])
         return wide[ACC_WIDTH-1:0];
      else if (wide[ACC_WIDTH])
         return {1'b1, {(ACC_WIDTH-1){1'b0}}};
      else
         return {1'b0, {(ACC_WIDTH-1){1'b1}}};
   endfunction

   // Rebuild outer, axis and inner counts and restart the tensor.
   function automatic void derive_counts();
      longint unsigned outer, inner, span;
      bit bad;
      int i;
      outer = 1;
      inner = 1;
      span  = 1;
      bad   = 1'b0;
      if (dims_used == 0 || dims_used > MAX_DIMS || dims_used > NUM_SHAPES)
         bad = 1'b1;
      else if (axis_sel >= dims_used)
         bad = 1'b1;
      else begin
         for (i = 0; i < dims_used; i++) begin
            if (shape_size[i] == 0 || shape_size[i] > SHAPE_MAX)
               bad = 1'b1;
            else if (i < axis_sel)
               outer *= shape_size[i];
            else if (i == axis_sel)
               span = shape_size[i];
            else
               inner *= shape_size[i];
         end
      end
      if (!bad && inner > INNER_DEPTH)
         bad = 1'b1;
      if (!bad && outer * inner > INDEX_SPAN)
         bad = 1'b1;
      config_bad  = bad;
      outer_count = bad ? 1 : outer;
      inner_count = bad ? 1 : inner;
      axis_count  = bad ? 1 : span;
      outer_pos   = 0;
      axis_pos    = 0;
      inner_pos   = 0;
   endfunction

   function automatic void note_register(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_SHAPE_0, CSR_SHAPE_1, CSR_SHAPE_2, CSR_SHAPE_3:
            shape_size[idx[$clog2(NUM_SHAPES)-1:0]] = d;
         CSR_REDUCE_AXIS: axis_sel = d[AXIS_W-1:0];
         CSR_NUM_DIMS: dims_used = d[NDIMS_W-1:0];
         default: ;
      endcase
      if (idx <= CSR_NUM_DIMS)
         derive_counts();
   endfunction

   function automatic void predict_element(input logic signed [VALUE_W-1:0] v);
      axis_sum_type r;
      sum_type acc;
      r = '0;
      if (config_bad || inner_pos >= INNER_DEPTH) begin
         r.config_error = 1'b1;
         expected_sums.push_back(r);
      end else begin
         acc = (axis_pos == 0) ? sum_type'(0) : partial_sum[inner_pos];
         acc = clamp_add(acc, v);
         partial_sum[inner_pos] = acc;
         if (axis_pos + 1 >= axis_count) begin
            r.sum_value   = acc;
            r.out_index   = INDEX_W'(outer_pos * inner_count + inner_pos);
            r.last_result = (outer_pos + 1 >= outer_count) && (inner_pos + 1 >= inner_count);
            expected_sums.push_back(r);
         end
         inner_pos++;
         if (inner_pos >= inner_count) begin
            inner_pos = 0;
            axis_pos++;
            if (axis_pos >= axis_count) begin
               axis_pos = 0;
               outer_pos++;
               if (outer_pos >= outer_count)
                  outer_pos = 0;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      axis_sum_type want, got;
      if (reset) begin
         for (int i = 0; i < NUM_SHAPES; i++)
            shape_size[i] = 1;
         axis_sel  = '0;
         dims_used = NDIMS_W'(1);
         derive_counts();
         expected_sums.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable)
            note_register(csr_index, csr_write_data);
         if (req_valid && !req_stall)
            predict_element(req_in_value);
         if (rsp_valid && !rsp_stall) begin
            got.sum_value    = rsp_sum_value;
            got.out_index    = rsp_out_index;
            got.last_result  = rsp_last_result;
            got.config_error = rsp_config_error;
            if (expected_sums.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("checker: unexpected result sum %h index %0d last %0b error %0b",
                           got.sum_value, got.out_index, got.last_result,
                           got.config_error);
            end else begin
               want = expected_sums.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"checker: mismatch sum %h/%h index %0d/%0d",
                               " last %0b/%0b error %0b/%0b (expected/actual)"},
                              want.sum_value, got.sum_value, want.out_index,
                              got.out_index, want.last_result, got.last_result,
                              want.config_error, got.config_error);
               end
            end
         end
      end
      pending_results = expected_sums.size();
   end

endmodule

[sim/tb.sv]
// Top of the tensor_axis_sum_reduce testbench: clock, reset, csr_ setup and req_/rsp_ traffic
// with random idling; the verdict comes from the failure count of tasr_sum_checker.
// Depends on tasr_pkg, tensor_axis_sum_reduce and tasr_sum_checker.
`timescale 1ns / 1ps

module tb
   import tasr_pkg::*;
();

   localparam int unsigned INNER_DEPTH = 1024;
   localparam int unsigned ACC_WIDTH   = 48;
   localparam int          ITEM_TARGET = 1300;
   localparam int          QUIET_TAIL  = 150;
   localparam int          CYCLE_LIMIT = 400000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [VALUE_W-1:0]   req_in_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [ACC_WIDTH-1:0] rsp_sum_value;
   logic [INDEX_W-1:0]          rsp_out_index;
   logic                        rsp_last_result;
   logic                        rsp_config_error;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_write_data = '0;

   int fail_count;
   int pending_results;
   int items_sent  = 0;
   int cycle_count = 0;
   bit idling_on   = 1'b1;

   always #4 clock = ~clock;

   tensor_axis_sum_reduce #(
      .INNER_DEPTH(INNER_DEPTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_value    (req_in_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sum_value   (rsp_sum_value),
      .rsp_out_index   (rsp_out_index),
      .rsp_last_result (rsp_last_result),
      .rsp_config_error(rsp_config_error),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   tasr_sum_checker #(
      .INNER_DEPTH(INNER_DEPTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) sum_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_value    (req_in_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sum_value   (rsp_sum_value),
      .rsp_out_index   (rsp_out_index),
      .rsp_last_result (rsp_last_result),
      .rsp_config_error(rsp_config_error),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // stall results in random bursts
   always begin
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(VALUE_W-1){1'b1}}};
         1: return {1'b1, {(VALUE_W-1){1'b0}}};
         2: return VALUE_W'(int'($urandom_range(0, 131071)) - 65536);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic send_element(input logic [VALUE_W-1:0] v);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_value <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // hold off until every sum is out and the pipeline has gone quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] d);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= d;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      repeat (8) @(negedge clock);
   endtask

   task automatic load_shape(input shape_type s0, input shape_type s1,
                             input shape_type s2, input shape_type s3,
                             input logic [AXIS_W-1:0] ax, input logic [NDIMS_W-1:0] nd);
      logic [CSR_DATA_W-1:0] pad;
      settle_block();
      pad = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      write_register(CSR_SHAPE_0, s0);
      write_register(CSR_SHAPE_1, s1);
      write_register(CSR_SHAPE_2, s2);
      write_register(CSR_SHAPE_3, s3);
      write_register(CSR_REDUCE_AXIS, {pad[CSR_DATA_W-1:AXIS_W], ax});
      write_register(CSR_NUM_DIMS, {pad[CSR_DATA_W-1:NDIMS_W], nd});
   endtask

   task automatic random_phase();
      shape_type          sz [NUM_SHAPES];
      logic [AXIS_W-1:0]  ax;
      logic [NDIMS_W-1:0] nd;
      int elems, count, i;
      case ($urandom_range(0, 15))
         0: begin
            load_shape(SHAPE_W'($urandom), SHAPE_W'($urandom), SHAPE_W'($urandom),
                       SHAPE_W'($urandom), AXIS_W'($urandom), NDIMS_W'($urandom));
            count = $urandom_range(3, 10);
         end
         1: begin
            case ($urandom_range(0, 2))
               0: begin
                  load_shape(2, 1024, SHAPE_W'($urandom), SHAPE_W'($urandom), 0, 2);
                  count = 60;
               end
               1: begin
                  load_shape(4096, 1, SHAPE_W'($urandom), SHAPE_W'($urandom), 1, 2);
                  count = 40;
               end
               default: begin
                  load_shape(4096, SHAPE_W'($urandom), SHAPE_W'($urandom),
                             SHAPE_W'($urandom), 0, 1);
                  count = 30;
               end
            endcase
         end
         default: begin
            nd = NDIMS_W'($urandom_range(1, MAX_DIMS));
            ax = AXIS_W'($urandom_range(0, nd - 1));
            elems = 1;
            for (i = 0; i < NUM_SHAPES; i++) begin
               if (i < nd) begin
                  sz[i] = SHAPE_W'($urandom_range(1, nd > 2 ? 3 : 6));
                  elems *= sz[i];
               end else
                  sz[i] = SHAPE_W'($urandom);
            end
            load_shape(sz[0], sz[1], sz[2], sz[3], ax, nd);
            count = elems * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
               count += $urandom_range(1, elems);
            if (count > 80)
               count = $urandom_range(20, 80);
         end
      endcase
      for (i = 0; i < count; i++) begin
         if (idling_on && $urandom_range(0, 39) == 0)
            settle_block();
         send_element(pick_value());
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset shape: axis of size one, each element is its own sum
      send_element({1'b0, {(VALUE_W-1){1'b1}}});
      send_element({1'b1, {(VALUE_W-1){1'b0}}});
      send_element('0);
      send_element('1);
      send_element(VALUE_W'(65536));

      // 2 x 3 summed over dimension one, extreme values
      load_shape(2, 3, 1, 1, 1, 2);
      repeat (3) send_element({1'b0, {(VALUE_W-1){1'b1}}});
      repeat (3) send_element({1'b1, {(VALUE_W-1){1'b0}}});

      // 1 x 2 x 2 over dimension one; unused indexes must not restart the tensor
      load_shape(1, 2, 2, SHAPE_W'($urandom), 1, 3);
      send_element(pick_value());
      send_element(pick_value());
      settle_block();
      write_register(CSR_IDX_W'(CSR_NUM_DIMS + 1), CSR_DATA_W'($urandom));
      write_register(CSR_IDX_W'(CSR_NUM_DIMS + 2), CSR_DATA_W'($urandom));
      send_element(pick_value());
      send_element(pick_value());

      // invalid setups: axis out of range, dimension count, bad shapes, inner count over INNER_DEPTH, too many sums
      load_shape(2, 2, 1, 1, 3, 2);
      send_element(pick_value());
      load_shape(1, 1, 1, 1, 0, 0);
      send_element(pick_value());
      load_shape(1, 1, 1, 1, 0, 5);
      send_element(pick_value());
      load_shape(1, 1, 1, 1, 0, 7);
      send_element(pick_value());
      load_shape(0, 1, 1, 1, 0, 1);
      send_element(pick_value());
      load_shape(2, 8191, 1, 1, 0, 2);
      send_element(pick_value());
      load_shape(1, 1025, 1, 1, 0, 2);
      send_element(pick_value());
      load_shape(4096, 4096, 2, 2, 2, 4);
      send_element(pick_value());

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_TAIL)
            idling_on = 1'b0;
         else
            idling_on = ($urandom_range(0, 3) != 0);
         random_phase();
      end

      settle_block();
      repeat (24) @(negedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

[files.f]
hw/rtl/tasr_pkg.sv
hw/rtl/tensor_axis_sum_reduce.sv
hw/rtl/tasr_checker.sv
sim/tasr_sum_checker.sv
sim/tb.sv
